// ----- sv/bmxt_pkg.sv -----
// ----------------------------------------------------------------------------
// bmxt_pkg
// Shared types and operation codes for the bounded max-XOR trie core.
// ----------------------------------------------------------------------------
package bmxt_pkg;

   localparam logic [1:0] OP_INSERT   = 2'd0;
   localparam logic [1:0] OP_QUERY    = 2'd1;
   localparam logic [1:0] OP_CLEAR    = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   localparam int FIELD_BITS = 31;

   typedef struct packed {
      logic [1:0]            func;
      logic [FIELD_BITS-1:0] value;
      logic [FIELD_BITS-1:0] limit;
   } req_type;

   typedef struct packed {
      logic                  found;
      logic [FIELD_BITS-1:0] max_xor;
      logic                  overflow;
   } rsp_type;

   // Classified command as it travels from the front end to the walker.
   typedef struct packed {
      logic [1:0]            op;
      logic [FIELD_BITS-1:0] value;
      logic [FIELD_BITS-1:0] limit;
   } cmd_type;

endpackage

// ----- sv/bmxt_ram.sv -----
// ----------------------------------------------------------------------------
// bmxt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bmxt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/bmxt_queue.sv -----
// ----------------------------------------------------------------------------
// bmxt_queue
// Two-entry command queue between the front end and the trie walker.
// ----------------------------------------------------------------------------
module bmxt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bmxt_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output bmxt_pkg::cmd_type head_cmd
);

   bmxt_pkg::cmd_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_cmd  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- sv/bmxt_front.sv -----
// ----------------------------------------------------------------------------
// bmxt_front
// Accepts request items, masks and saturates operands, drops unused codes and
// hands commands to the queue.
// ----------------------------------------------------------------------------
module bmxt_front #(
   parameter int VALUE_BITS = 31
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bmxt_pkg::req_type req_data,
   output logic              push,
   output bmxt_pkg::cmd_type push_cmd,
   input  logic              queue_full
);

   localparam logic [31:0] MASK32 = (VALUE_BITS >= 32) ? 32'hFFFF_FFFF :
                                    ((32'd1 << VALUE_BITS) - 32'd1);
   localparam logic [bmxt_pkg::FIELD_BITS-1:0] MASK = MASK32[bmxt_pkg::FIELD_BITS-1:0];

   logic              hold_valid_ff, hold_valid_in;
   bmxt_pkg::cmd_type hold_cmd_ff, hold_cmd_in;
   logic              accept;
   logic              keep;

   assign busy     = hold_valid_ff && queue_full;
   assign accept   = start && !busy;
   assign push     = hold_valid_ff && !queue_full;
   assign push_cmd = hold_cmd_ff;

   // The unused operation code is dropped here and never reaches the walker.
   assign keep = (req_data.func == bmxt_pkg::OP_INSERT) ||
                 (req_data.func == bmxt_pkg::OP_QUERY)  ||
                 (req_data.func == bmxt_pkg::OP_CLEAR);

   always_comb begin
      hold_valid_in = hold_valid_ff && !push;
      hold_cmd_in   = hold_cmd_ff;
      if (accept) begin
         hold_valid_in     = keep;
         hold_cmd_in.op    = req_data.func;
         hold_cmd_in.value = req_data.value & MASK;
         if ((req_data.limit & ~MASK) != '0) begin
            hold_cmd_in.limit = MASK;
         end else begin
            hold_cmd_in.limit = req_data.limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end

endmodule

// ----- sv/bmxt_back.sv -----
// ----------------------------------------------------------------------------
// bmxt_back
// Trie walker: runs inserts, queries and clears against the node memory, one
// trie level per cycle.
// ----------------------------------------------------------------------------
module bmxt_back #(
   parameter int VALUE_BITS = 31,
   parameter int NODE_DEPTH = 32768
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_ready,
   input  bmxt_pkg::cmd_type cmd,
   output logic              pop,
   output logic              rsp_valid,
   output bmxt_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(NODE_DEPTH);
   localparam int LW = $clog2(VALUE_BITS);
   localparam int VB = VALUE_BITS;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_WRITE  = 3'd3;
   localparam logic [2:0] ST_QUERY  = 3'd4;

   // Each node holds both child links and the minimum stored under each child.
   typedef struct packed {
      logic          v1;
      logic          v0;
      logic [AW-1:0] c1;
      logic [AW-1:0] c0;
      logic [VB-1:0] m1;
      logic [VB-1:0] m0;
   } node_type;

   localparam int NW = $bits(node_type);

   logic [2:0]    state_ff, state_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic          at_root_ff, at_root_in;
   logic          is_new_ff, is_new_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [VB-1:0] val_ff, val_in;
   logic [VB-1:0] lim_ff, lim_in;
   logic [VB-1:0] ans_ff, ans_in;
   logic [LW:0]   need_ff, need_in;
   logic [AW:0]   used_ff, used_in;
   node_type      root_ff, root_in;
   logic          rsp_valid_ff, rsp_valid_in;
   bmxt_pkg::rsp_type rsp_ff, rsp_in;

   logic [NW-1:0] ram_rdata;
   logic          ram_we;
   logic [AW-1:0] ram_raddr;
   node_type      node_new;
   node_type      node;
   logic          b, vb, vt;
   logic [AW-1:0] cb, ct;
   logic [VB-1:0] mb, mt;
   logic          root_hit;

   bmxt_ram #(
      .WIDTH(NW),
      .DEPTH(NODE_DEPTH)
   ) u_node_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(cur_ff),
      .wr_data(node_new),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // A freshly allocated node is read as empty instead of from memory.
   always_comb begin
      if (at_root_ff) begin
         node = root_ff;
      end else if (is_new_ff) begin
         node = '0;
      end else begin
         node = node_type'(ram_rdata);
      end
      b  = val_ff[lvl_ff];
      vb = b ? node.v1 : node.v0;
      cb = b ? node.c1 : node.c0;
      mb = b ? node.m1 : node.m0;
      vt = b ? node.v0 : node.v1;
      ct = b ? node.c0 : node.c1;
      mt = b ? node.m0 : node.m1;
      root_hit = (root_ff.v0 && (root_ff.m0 <= lim_ff)) ||
                 (root_ff.v1 && (root_ff.m1 <= lim_ff));
   end

   always_comb begin
      state_in     = state_ff;
      lvl_in       = lvl_ff;
      at_root_in   = at_root_ff;
      is_new_in    = is_new_ff;
      cur_in       = cur_ff;
      val_in       = val_ff;
      lim_in       = lim_ff;
      ans_in       = ans_ff;
      need_in      = need_ff;
      used_in      = used_ff;
      root_in      = root_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      ram_we       = 1'b0;
      ram_raddr    = cb;
      node_new     = node;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_ready) begin
               pop        = 1'b1;
               val_in     = VB'(cmd.value);
               lim_in     = VB'(cmd.limit);
               lvl_in     = LW'(VB - 1);
               at_root_in = 1'b1;
               is_new_in  = 1'b0;
               ans_in     = '0;
               case (cmd.op)
                  bmxt_pkg::OP_INSERT: state_in = ST_CHECK;
                  bmxt_pkg::OP_QUERY:  state_in = ST_QUERY;
                  bmxt_pkg::OP_CLEAR: begin
                     root_in.v0 = 1'b0;
                     root_in.v1 = 1'b0;
                     used_in    = (AW+1)'(1);
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         // First pass: find how many new nodes the insert needs.
         ST_CHECK: begin
            if (!vb) begin
               need_in  = (LW+1)'(lvl_ff) + (LW+1)'(1);
               state_in = ST_DECIDE;
            end else if (lvl_ff == '0) begin
               need_in  = '0;
               state_in = ST_DECIDE;
            end else begin
               ram_raddr  = cb;
               cur_in     = cb;
               at_root_in = 1'b0;
               lvl_in     = lvl_ff - LW'(1);
            end
         end

         ST_DECIDE: begin
            if ((32'(used_ff) + 32'(need_ff)) > 32'(NODE_DEPTH)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{found: 1'b0, max_xor: '0, overflow: 1'b1};
               state_in     = ST_IDLE;
            end else begin
               at_root_in = 1'b1;
               is_new_in  = 1'b0;
               lvl_in     = LW'(VB - 1);
               state_in   = ST_WRITE;
            end
         end

         // Second pass: update minima along the path and link new nodes.
         ST_WRITE: begin
            if (vb) begin
               if (val_ff < mb) begin
                  if (b) node_new.m1 = val_ff;
                  else   node_new.m0 = val_ff;
               end
               ram_raddr = cb;
               is_new_in = 1'b0;
               cur_in    = cb;
            end else begin
               if (b) begin
                  node_new.v1 = 1'b1;
                  node_new.c1 = used_ff[AW-1:0];
                  node_new.m1 = val_ff;
               end else begin
                  node_new.v0 = 1'b1;
                  node_new.c0 = used_ff[AW-1:0];
                  node_new.m0 = val_ff;
               end
               ram_raddr = used_ff[AW-1:0];
               is_new_in = 1'b1;
               cur_in    = used_ff[AW-1:0];
               used_in   = used_ff + (AW+1)'(1);
            end
            if (at_root_ff) begin
               root_in = node_new;
            end else begin
               ram_we = 1'b1;
            end
            at_root_in = 1'b0;
            if (lvl_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{found: 1'b0, max_xor: '0, overflow: 1'b0};
               state_in     = ST_IDLE;
            end else begin
               lvl_in = lvl_ff - LW'(1);
            end
         end

         ST_QUERY: begin
            at_root_in = 1'b0;
            lvl_in     = lvl_ff - LW'(1);
            if (at_root_ff && !root_hit) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{found: 1'b0, max_xor: '0, overflow: 1'b0};
               state_in     = ST_IDLE;
            end else if (vt && (mt <= lim_ff)) begin
               ram_raddr      = ct;
               cur_in         = ct;
               ans_in[lvl_ff] = 1'b1;
               if (lvl_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{found: 1'b1, max_xor: bmxt_pkg::FIELD_BITS'(ans_in),
                                   overflow: 1'b0};
                  state_in     = ST_IDLE;
               end
            end else if (vb) begin
               ram_raddr = cb;
               cur_in    = cb;
               if (lvl_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{found: 1'b1, max_xor: bmxt_pkg::FIELD_BITS'(ans_ff),
                                   overflow: 1'b0};
                  state_in     = ST_IDLE;
               end
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{found: 1'b1, max_xor: bmxt_pkg::FIELD_BITS'(ans_ff),
                                overflow: 1'b0};
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= (AW+1)'(1);
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lvl_ff     <= lvl_in;
      at_root_ff <= at_root_in;
      is_new_ff  <= is_new_in;
      cur_ff     <= cur_in;
      val_ff     <= val_in;
      lim_ff     <= lim_in;
      ans_ff     <= ans_in;
      need_ff    <= need_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= 32'(NODE_DEPTH))
      else $error("node count passed the node table size");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   a_ovf_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.overflow) |-> !rsp_ff.found)
      else $error("overflow reported on a query result");

   a_write_old_node: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && !at_root_ff && !is_new_ff) |-> (AW+1)'(cur_ff) < used_ff)
      else $error("insert walked into an unallocated node");

endmodule

// ----- sv/bounded_max_xor_trie_core.sv -----
// ----------------------------------------------------------------------------
// bounded_max_xor_trie_core
// Binary trie over stored values with insert, clear and bounded max-XOR query.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   start, busy, req_data          taken when start && !busy
//  result    rsp_valid, rsp_data            one-cycle strobe, no backpressure
//
//  The walker reads one node memory word per trie level. After the accepting
//  edge an item waits in the front register and then in the queue before the
//  walker can pop it; an insert then runs pop, checking walk, decision and
//  updating walk, a query runs pop and querying walk, a clear only the pop,
//  and the result strobe is registered. Reset is synchronous and leaves an
//  empty trie, with no memory sweep. Up to three items are buffered ahead of
//  the walker; busy rises while that buffer is full.
// ----------------------------------------------------------------------------
module bounded_max_xor_trie_core #(
   parameter int VALUE_BITS = 31,
   parameter int NODE_DEPTH = 32768
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bmxt_pkg::req_type req_data,
   output logic              rsp_valid,
   output bmxt_pkg::rsp_type rsp_data
);

   logic              push;
   bmxt_pkg::cmd_type push_cmd;
   logic              queue_full;
   logic              pop;
   logic              not_empty;
   bmxt_pkg::cmd_type head_cmd;

   bmxt_front #(
      .VALUE_BITS(VALUE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .push      (push),
      .push_cmd  (push_cmd),
      .queue_full(queue_full)
   );

   bmxt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .not_empty(not_empty),
      .head_cmd (head_cmd)
   );

   bmxt_back #(
      .VALUE_BITS(VALUE_BITS),
      .NODE_DEPTH(NODE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_ready(not_empty),
      .cmd      (head_cmd),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule
